/* rtl/core/g2s_pkg.sv */
// Shared types, constants and key tables of the gamepad to scancode bridge.
`timescale 1ns / 1ps

package g2s_pkg;

    localparam int NUM_BUTTONS  = 14;
    localparam int TIME_BITS    = 48;
    localparam int CFG_BITS     = 24;
    localparam int CFG_IDX_BITS = 8;
    localparam int CODE_BITS    = 7;
    localparam int BTN_IDX_BITS = $clog2(NUM_BUTTONS);

    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TIME = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_TAP_TIME  = CFG_IDX_BITS'(1);

    localparam logic [CFG_BITS-1:0] HOLD_TIME_RESET = CFG_BITS'(500000);
    localparam logic [CFG_BITS-1:0] TAP_TIME_RESET  = CFG_BITS'(35000);

    localparam int SYS_KEYS = 2;
    localparam logic [BTN_IDX_BITS-1:0] SYS_BIT [SYS_KEYS] = '{
        BTN_IDX_BITS'(6), BTN_IDX_BITS'(7)
    };
    localparam logic [CODE_BITS-1:0] SYS_CODE [SYS_KEYS] = '{7'h01, 7'h0f};

    localparam int KEY_COUNT    = 14;
    localparam int KEY_IDX_BITS = $clog2(KEY_COUNT);
    localparam logic [BTN_IDX_BITS-1:0] KEY_BIT [KEY_COUNT] = '{
        BTN_IDX_BITS'(0),  BTN_IDX_BITS'(2),  BTN_IDX_BITS'(3),  BTN_IDX_BITS'(1),
        BTN_IDX_BITS'(8),  BTN_IDX_BITS'(8),  BTN_IDX_BITS'(9),  BTN_IDX_BITS'(9),
        BTN_IDX_BITS'(10), BTN_IDX_BITS'(11), BTN_IDX_BITS'(4),  BTN_IDX_BITS'(5),
        BTN_IDX_BITS'(12), BTN_IDX_BITS'(13)
    };
    localparam logic [CODE_BITS-1:0] KEY_CODE [KEY_COUNT] = '{
        7'h48, 7'h50, 7'h4b, 7'h4d, 7'h1d, 7'h1c, 7'h36,
        7'h38, 7'h39, 7'h1c, 7'h1c, 7'h39, 7'h33, 7'h34
    };

    localparam int SLOT_COUNT    = 8 + KEY_COUNT;
    localparam int SLOT_IDX_BITS = $clog2(SLOT_COUNT);
    localparam int MAX_EVENTS    = 20;

    localparam logic [SLOT_IDX_BITS-1:0] SLOT_BRK   [SYS_KEYS] = '{
        SLOT_IDX_BITS'(0), SLOT_IDX_BITS'(1)
    };
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_REQ   [SYS_KEYS] = '{
        SLOT_IDX_BITS'(2), SLOT_IDX_BITS'(5)
    };
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_FLUSH [SYS_KEYS] = '{
        SLOT_IDX_BITS'(3), SLOT_IDX_BITS'(6)
    };
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_MAKE  [SYS_KEYS] = '{
        SLOT_IDX_BITS'(4), SLOT_IDX_BITS'(7)
    };
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_TABLE = SLOT_IDX_BITS'(8);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        KIND_MAKE      = 3'd0,
        KIND_BREAK     = 3'd1,
        KIND_FLUSH     = 3'd2,
        KIND_GAME_MENU = 3'd3,
        KIND_OPT_MENU  = 3'd4
    } t_kind;

    typedef struct packed {
        logic pend;
        logic held_long;
        logic down;
    } t_sys_flags;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] mask;
        logic [KEY_COUNT-1:0]  make;
    } t_work;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

/* rtl/core/g2s_ifs.sv */
// Valid/ready channel interfaces for samples, events and register writes.
`timescale 1ns / 1ps

interface g2s_sample_if;
    logic                            valid;
    logic                            ready;
    logic [g2s_pkg::NUM_BUTTONS-1:0] buttons;
    logic [g2s_pkg::TIME_BITS-1:0]   now_us;

    modport source (output valid, output buttons, output now_us, input ready);
    modport sink   (input valid, input buttons, input now_us, output ready);
endinterface

interface g2s_event_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    event_kind;
    logic [g2s_pkg::CODE_BITS-1:0] scan_code;
    logic                          last;

    modport source (output valid, output event_kind, output scan_code, output last,
                    input ready);
    modport sink   (input valid, input event_kind, input scan_code, input last,
                    output ready);
endinterface

interface g2s_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [g2s_pkg::CFG_IDX_BITS-1:0] index;
    logic [g2s_pkg::CFG_BITS-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/g2s_front.sv */
// Front end: takes samples, tracks button state and classifies the events of each item.
`timescale 1ns / 1ps

module g2s_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    g2s_sample_if.sink            i_sample,
    g2s_cfg_if.sink               i_cfg,
    input  g2s_pkg::t_q_stat      i_q_stat,
    output logic                  o_push,
    output g2s_pkg::t_work        o_work
);

    localparam int NB = g2s_pkg::NUM_BUTTONS;
    localparam int TB = g2s_pkg::TIME_BITS;

    logic [g2s_pkg::CFG_BITS-1:0] r_hold, r_tap;
    logic [NB-1:0]                r_prev, n_prev;
    logic [NB-1:0]                r_supp, n_supp;
    g2s_pkg::t_sys_flags          r_flags [g2s_pkg::SYS_KEYS];
    g2s_pkg::t_sys_flags          n_flags [g2s_pkg::SYS_KEYS];
    logic [TB-1:0]                r_start [g2s_pkg::SYS_KEYS];
    logic [TB-1:0]                n_start [g2s_pkg::SYS_KEYS];
    logic [TB-1:0]                r_rel   [g2s_pkg::SYS_KEYS];
    logic [TB-1:0]                n_rel   [g2s_pkg::SYS_KEYS];
    logic                         accept;

    assign i_sample.ready = !i_q_stat.full;
    assign i_cfg.ready    = 1'b1;
    assign accept         = i_sample.valid && i_sample.ready;

    always_comb begin
        logic [NB-1:0]       raw;
        logic [NB-1:0]       supp;
        logic [NB-1:0]       joy;
        logic [NB-1:0]       changed;
        logic [TB-1:0]       now;
        logic [TB-1:0]       start;
        logic [TB-1:0]       held;
        logic [TB:0]         tap_sum;
        logic                pressed;
        g2s_pkg::t_sys_flags f;
        g2s_pkg::t_work      w;

        raw     = i_sample.buttons;
        now     = i_sample.now_us;
        w       = '0;
        tap_sum = '0;
        n_flags = r_flags;
        n_start = r_start;
        n_rel   = r_rel;

        for (int k = 0; k < g2s_pkg::SYS_KEYS; k++) begin
            if (r_flags[k].pend && now >= r_rel[k]) begin
                w.mask[g2s_pkg::SLOT_BRK[k]] = 1'b1;
                n_flags[k].pend = 1'b0;
            end
        end

        supp = r_supp & raw;
        joy  = raw & ~supp;

        for (int k = 0; k < g2s_pkg::SYS_KEYS; k++) begin
            f       = n_flags[k];
            pressed = joy[g2s_pkg::SYS_BIT[k]];
            start   = r_start[k];
            if (pressed && !f.down) begin
                f.down      = 1'b1;
                f.held_long = 1'b0;
                start       = now;
            end
            held = (now >= start) ? now - start : '0;
            if (pressed && !f.held_long && held >= TB'(r_hold)) begin
                f.held_long = 1'b1;
                w.mask[g2s_pkg::SLOT_REQ[k]]   = 1'b1;
                w.mask[g2s_pkg::SLOT_FLUSH[k]] = 1'b1;
                supp    = supp | raw;
                joy     = joy & ~supp;
                pressed = 1'b0;
            end
            if (!pressed && f.down) begin
                if (!f.held_long) begin
                    w.mask[g2s_pkg::SLOT_MAKE[k]] = 1'b1;
                    f.pend   = 1'b1;
                    tap_sum  = {1'b0, now} + (TB + 1)'(r_tap);
                    n_rel[k] = tap_sum[TB] ? '1 : tap_sum[TB-1:0];
                end
                f.down      = 1'b0;
                f.held_long = 1'b0;
            end
            n_flags[k] = f;
            n_start[k] = start;
        end

        changed = joy ^ r_prev;
        for (int i = 0; i < g2s_pkg::KEY_COUNT; i++) begin
            w.mask[g2s_pkg::SLOT_TABLE + i] = changed[g2s_pkg::KEY_BIT[i]];
            w.make[i]                       = joy[g2s_pkg::KEY_BIT[i]];
        end

        n_prev = joy;
        n_supp = supp;
        o_work = w;
        o_push = accept && (w.mask != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= g2s_pkg::HOLD_TIME_RESET;
            r_tap  <= g2s_pkg::TAP_TIME_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == g2s_pkg::REG_HOLD_TIME) begin
                r_hold <= i_cfg.data;
            end else if (i_cfg.index == g2s_pkg::REG_TAP_TIME) begin
                r_tap <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_supp <= '0;
            for (int k = 0; k < g2s_pkg::SYS_KEYS; k++) begin
                r_flags[k] <= '0;
                r_start[k] <= '0;
                r_rel[k]   <= '0;
            end
        end else if (accept) begin
            r_prev  <= n_prev;
            r_supp  <= n_supp;
            r_flags <= n_flags;
            r_start <= n_start;
            r_rel   <= n_rel;
        end
    end

`ifndef ASSERT_OFF
    a_prev_not_suppressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prev & r_supp) == '0)
        else $error("suppressed button reported as held");

    a_event_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> $countones(o_work.mask) <= g2s_pkg::MAX_EVENTS)
        else $error("too many events for one item");
`endif

endmodule

/* rtl/core/g2s_queue.sv */
// Short work queue between the front and back ends.
`timescale 1ns / 1ps

module g2s_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  g2s_pkg::t_work   i_work,
    input  logic             i_pop,
    output g2s_pkg::t_work   o_head,
    output g2s_pkg::t_q_stat o_stat
);

    localparam int QB = g2s_pkg::QPTR_BITS;

    g2s_pkg::t_work r_mem [g2s_pkg::QUEUE_DEPTH];
    logic [QB-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QB:0]    r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (QB + 1)'(g2s_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full || i_pop)
        else $error("push into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QB + 1)'(g2s_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

/* rtl/core/g2s_back.sv */
// Back end: serializes the events of each queued item onto the output channel.
`timescale 1ns / 1ps

module g2s_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  g2s_pkg::t_work   i_head,
    input  g2s_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    g2s_event_if.source      o_event
);

    localparam int SC = g2s_pkg::SLOT_COUNT;
    localparam int SB = g2s_pkg::SLOT_IDX_BITS;

    logic                              r_busy;
    logic [SC-1:0]                     r_mask;
    logic [g2s_pkg::KEY_COUNT-1:0]     r_make;
    logic                              r_out_valid;
    g2s_pkg::t_kind                    r_kind;
    logic [g2s_pkg::CODE_BITS-1:0]     r_code;
    logic                              r_last;

    logic [SB-1:0]                     idx;
    logic [g2s_pkg::KEY_IDX_BITS-1:0]  tidx;
    logic [SC-1:0]                     rest;
    g2s_pkg::t_kind                    kind;
    logic [g2s_pkg::CODE_BITS-1:0]     code;
    logic                              advance, finish, load;

    always_comb begin
        idx = '0;
        for (int j = SC - 1; j >= 0; j--) begin
            if (r_mask[j]) begin
                idx = SB'(j);
            end
        end
    end

    assign rest = r_mask & ~(SC'(1) << idx);
    assign tidx = g2s_pkg::KEY_IDX_BITS'(idx - g2s_pkg::SLOT_TABLE);

    always_comb begin
        kind = g2s_pkg::KIND_FLUSH;
        code = '0;
        case (idx)
            g2s_pkg::SLOT_BRK[0]: begin
                kind = g2s_pkg::KIND_BREAK;
                code = g2s_pkg::SYS_CODE[0];
            end
            g2s_pkg::SLOT_BRK[1]: begin
                kind = g2s_pkg::KIND_BREAK;
                code = g2s_pkg::SYS_CODE[1];
            end
            g2s_pkg::SLOT_REQ[0]: begin
                kind = g2s_pkg::KIND_GAME_MENU;
            end
            g2s_pkg::SLOT_REQ[1]: begin
                kind = g2s_pkg::KIND_OPT_MENU;
            end
            g2s_pkg::SLOT_FLUSH[0], g2s_pkg::SLOT_FLUSH[1]: begin
                kind = g2s_pkg::KIND_FLUSH;
            end
            g2s_pkg::SLOT_MAKE[0]: begin
                kind = g2s_pkg::KIND_MAKE;
                code = g2s_pkg::SYS_CODE[0];
            end
            g2s_pkg::SLOT_MAKE[1]: begin
                kind = g2s_pkg::KIND_MAKE;
                code = g2s_pkg::SYS_CODE[1];
            end
            default: begin
                kind = r_make[tidx] ? g2s_pkg::KIND_MAKE : g2s_pkg::KIND_BREAK;
                code = g2s_pkg::KEY_CODE[tidx];
            end
        endcase
    end

    assign advance = r_busy && (!r_out_valid || o_event.ready);
    assign finish  = advance && (rest == '0);
    assign load    = (!r_busy || finish) && !i_q_stat.empty;
    assign o_pop   = load;

    assign o_event.valid      = r_out_valid;
    assign o_event.event_kind = r_kind;
    assign o_event.scan_code  = r_code;
    assign o_event.last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_event.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mask <= i_head.mask;
            r_make <= i_head.make;
        end else if (advance) begin
            r_mask <= rest;
        end
        if (advance) begin
            r_kind <= kind;
            r_code <= code;
            r_last <= (rest == '0);
        end
    end

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_stat.empty)
        else $error("pop from empty queue");

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_mask != '0)
        else $error("busy with no events left");
`endif

endmodule

/* rtl/core/gamepad_to_scancode_bridge.sv */
// Top level of the gamepad to scancode bridge.
`timescale 1ns / 1ps

// Turns gamepad samples into keyboard make/break scancode events plus menu and
// flush requests. The front end takes one sample per cycle while its
// four-entry work queue has room; a sample that causes no event queues
// nothing. The back end drives one event per cycle on the output channel
// while the output is ready, and a sample yields up to 20 events, so that
// single output port sets the sustained rate. The final event of each
// sample carries last. Register writes take effect at once and belong in
// idle periods; there is no clearing pass after reset.
module gamepad_to_scancode_bridge (
    input  logic         i_clk,
    input  logic         i_rst_n,
    g2s_sample_if.sink   i_sample,
    g2s_cfg_if.sink      i_cfg,
    g2s_event_if.source  o_event
);

    logic             push, pop;
    g2s_pkg::t_work   work, head;
    g2s_pkg::t_q_stat q_stat;

    g2s_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_cfg    (i_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_work   (work)
    );

    g2s_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (work),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    g2s_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_event  (o_event)
    );

endmodule
